// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each use states one property on one line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdb assertion failed");

`endif

// File: hw/rtl/pdb_pkg.sv
`default_nettype none

package pdb_pkg;

    localparam int COORD_W    = 16;
    localparam int ANGLE_FRAC = 6;
    localparam int ROT_STAGES = 18;

    localparam int Z_FRAC    = 16;
    localparam int PRE_SHIFT = 48 - COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int XY_W      = 53;
    localparam int Z_W       = 26;
    localparam int SUM_W     = 2 * COORD_W + 1;
    localparam int ROOT_W    = (SUM_W + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int NSTG      = (ROT_STAGES > ROOT_W) ? ROT_STAGES : ROOT_W;
    localparam int RND_SH    = Z_FRAC - ANGLE_FRAC;

    localparam int DIST_W = 17;
    localparam int BEAR_W = 15;

    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [Z_W-1:0]    HALF_TURN = Z_W'(180 * (2 ** Z_FRAC));
    localparam logic [Z_W-1:0]    FULL_TURN = Z_W'(360 * (2 ** Z_FRAC));
    localparam logic [Z_W-1:0]    RND_HALF  = Z_W'(2 ** (RND_SH - 1));
    localparam logic [Z_W-1:0]    OUT_TURN  = Z_W'(360 * (2 ** ANGLE_FRAC));

    // Rotation angles atan(2^-i) in units of 2^-16 degree.
    localparam logic [21:0] ATAN_TAB [32] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   coinc;
        logic [RAD_W-1:0]       rad;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
    } pdb_work_t;

endpackage

`default_nettype wire

// File: hw/rtl/pdb_in_if.sv
`default_nettype none

interface pdb_in_if;
    import pdb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;

    modport source (
        output valid, origin_x, origin_y, target_x, target_y,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, target_x, target_y,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/pdb_out_if.sv
`default_nettype none

interface pdb_out_if;
    import pdb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [BEAR_W-1:0] bearing;

    modport source (
        output valid, distance, bearing,
        input  ready
    );

    modport sink (
        input  valid, distance, bearing,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/point_distance_and_bearing.sv
// Channel  Role    Payload
// pts      sink    origin_x, origin_y, target_x, target_y (signed, 4 fraction bits)
// res      source  distance (unsigned, 4 fraction bits), bearing (1/64 degree)
//
// One item is accepted every cycle while res is not stalled; the pipeline has three front stages,
// one stage per CORDIC rotation and square-root digit, and one rounding stage.
// The rotation pipeline depth of 18 stages sets the latency.
// Reset clears only the valid bits; the data registers are not reset.
// A stall at res holds the output; stages behind it keep filling empty slots.
`default_nettype none

`include "assert_macros.svh"

module point_distance_and_bearing (
    input wire logic clk,
    input wire logic rst_n,
    pdb_in_if.sink   pts,
    pdb_out_if.source res
);
    import pdb_pkg::*;

    logic en_a, en_b, en_c, en_d;
    logic va_reg, vb_reg, vc_reg, vd_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next;

    logic [COORD_W-1:0]     ax, ay;
    logic [2*COORD_W-1:0]   sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic signed [DIFF_W-1:0] xn, yn;
    pdb_work_t              wb_reg, wb_next;
    pdb_work_t              wc_reg, wc_next;

    logic                   core_in_ready;
    logic                   core_out_valid;
    pdb_work_t              core_out;

    logic [ROOT_W:0]        dfull;
    logic [Z_W-1:0]         ang_u, ang_r;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic [BEAR_W-1:0]      bear_reg, bear_next;

    assign en_d = ~vd_reg | res.ready;
    assign en_c = ~vc_reg | core_in_ready;
    assign en_b = ~vb_reg | en_c;
    assign en_a = ~va_reg | en_b;

    assign pts.ready = en_a;

    always_comb
    begin
        dx_next = DIFF_W'(pts.target_x) - DIFF_W'(pts.origin_x);
        dy_next = DIFF_W'(pts.target_y) - DIFF_W'(pts.origin_y);
    end

    // Squares for the distance and the half-plane fold for the rotation.
    always_comb
    begin
        ax = dx_reg[DIFF_W-1] ? COORD_W'(-dx_reg) : COORD_W'(dx_reg);
        ay = dy_reg[DIFF_W-1] ? COORD_W'(-dy_reg) : COORD_W'(dy_reg);
        sqx_next = ax * ax;
        sqy_next = ay * ay;

        xn = dx_reg[DIFF_W-1] ? -dx_reg : dx_reg;
        yn = dx_reg[DIFF_W-1] ? -dy_reg : dy_reg;

        wb_next       = '0;
        wb_next.x     = $signed({{(XY_W-DIFF_W){xn[DIFF_W-1]}}, xn}) <<< PRE_SHIFT;
        wb_next.y     = $signed({{(XY_W-DIFF_W){yn[DIFF_W-1]}}, yn}) <<< PRE_SHIFT;
        wb_next.z     = dx_reg[DIFF_W-1] ? $signed(HALF_TURN) : '0;
        wb_next.coinc = (dx_reg == '0) && (dy_reg == '0);
    end

    always_comb
    begin
        wc_next     = wb_reg;
        wc_next.rad = RAD_W'({1'b0, sqx_reg} + {1'b0, sqy_reg});
        wc_next.rem = '0;
        wc_next.root = '0;
    end

    pdb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .in_ready  (core_in_ready),
        .in_work   (wc_reg),
        .out_valid (core_out_valid),
        .out_ready (en_d),
        .out_work  (core_out)
    );

    // Rounding and saturation of the root; wrap and rounding of the angle, zero for coincident points.
    always_comb
    begin
        dfull = {1'b0, core_out.root} +
                (ROOT_W+1)'(REM_W'(core_out.rem) > REM_W'(core_out.root));
        if (dfull > (ROOT_W+1)'(DIST_MAX))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = DIST_W'(dfull);
        end

        ang_u = core_out.z[Z_W-1] ? Z_W'(core_out.z) + FULL_TURN : Z_W'(core_out.z);
        ang_r = (ang_u + RND_HALF) >> RND_SH;
        if (ang_r >= OUT_TURN)
        begin
            ang_r = ang_r - OUT_TURN;
        end
        bear_next = core_out.coinc ? '0 : BEAR_W'(ang_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= pts.valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
            if (en_c)
            begin
                vc_reg <= vb_reg;
            end
            if (en_d)
            begin
                vd_reg <= core_out_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && pts.valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en_b && va_reg)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            wb_reg  <= wb_next;
        end
        if (en_c && vb_reg)
        begin
            wc_reg <= wc_next;
        end
        if (en_d && core_out_valid)
        begin
            dist_reg <= dist_next;
            bear_reg <= bear_next;
        end
    end

    assign res.valid    = vd_reg;
    assign res.distance = dist_reg;
    assign res.bearing  = bear_reg;

    `PDB_ASSERT_SAME(a_zero_dist_zero_bear, clk, rst_n, res.valid && (res.distance == '0), res.bearing == '0)
    `PDB_ASSERT_SAME(a_bear_in_turn, clk, rst_n, res.valid, Z_W'(res.bearing) < OUT_TURN)
    `PDB_ASSERT_NEXT(a_accept_loads_front, clk, rst_n, pts.valid && pts.ready, va_reg)

endmodule

`default_nettype wire

// File: hw/rtl/pdb_core.sv
`default_nettype none

module pdb_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pdb_pkg::pdb_work_t in_work,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pdb_pkg::pdb_work_t      out_work
);
    import pdb_pkg::*;

    // One CORDIC vectoring rotation per stage, and one square-root digit in each stage below ROOT_W.
    function automatic pdb_work_t iter_step(pdb_work_t w, int j);
        pdb_work_t              r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  ang;
        logic [REM_W-1:0]       rem_s;
        logic [REM_W-1:0]       trial;
        begin
            r = w;
            if (j < ROT_STAGES)
            begin
                xs  = w.x >>> j;
                ys  = w.y >>> j;
                ang = $signed(Z_W'(ATAN_TAB[5'(j)]));
                if (!w.y[XY_W-1])
                begin
                    r.x = w.x + ys;
                    r.y = w.y - xs;
                    r.z = w.z + ang;
                end
                else
                begin
                    r.x = w.x - ys;
                    r.y = w.y + xs;
                    r.z = w.z - ang;
                end
            end
            if (j < ROOT_W)
            begin
                rem_s = {w.rem[REM_W-3:0], w.rad[RAD_W-1 -: 2]};
                trial = {w.root, 2'b01};
                if (rem_s >= trial)
                begin
                    r.rem  = rem_s - trial;
                    r.root = {w.root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    r.rem  = rem_s;
                    r.root = {w.root[ROOT_W-2:0], 1'b0};
                end
                r.rad = w.rad << 2;
            end
            return r;
        end
    endfunction

    logic      [NSTG-1:0] valid_reg;
    logic      [NSTG-1:0] en;
    pdb_work_t            work_reg  [NSTG];
    pdb_work_t            work_next [NSTG];

    assign en[NSTG-1] = ~valid_reg[NSTG-1] | out_ready;

    genvar j;
    generate
        for (j = 0; j < NSTG; j++)
        begin : g_stage
            if (j < NSTG - 1)
            begin : g_en
                assign en[j] = ~valid_reg[j] | en[j+1];
            end

            if (j == 0)
            begin : g_first
                always_comb
                begin
                    work_next[j] = iter_step(in_work, j);
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        valid_reg[j] <= 1'b0;
                    end
                    else if (en[j])
                    begin
                        valid_reg[j] <= in_valid;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en[j] && in_valid)
                    begin
                        work_reg[j] <= work_next[j];
                    end
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    work_next[j] = iter_step(work_reg[j-1], j);
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        valid_reg[j] <= 1'b0;
                    end
                    else if (en[j])
                    begin
                        valid_reg[j] <= valid_reg[j-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en[j] && valid_reg[j-1])
                    begin
                        work_reg[j] <= work_next[j];
                    end
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_work  = work_reg[NSTG-1];

endmodule

`default_nettype wire

// File: test/tb_point_distance_and_bearing.sv
`default_nettype none

module tb_point_distance_and_bearing;
    timeunit 1ns;
    timeprecision 1ps;

    import pdb_pkg::COORD_W;
    import pdb_pkg::DIST_W;
    import pdb_pkg::BEAR_W;

    localparam int     RANDOM_ITEMS = 800;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     QUIET_LIMIT  = 3000;
    localparam int     CORDIC_STEPS = 18;
    localparam int     ANGLE_FRAC   = 16;
    localparam int     UNIT_SHIFT   = 10;
    localparam longint HALF_TURN    = 64'sd180 <<< ANGLE_FRAC;
    localparam longint FULL_TURN    = 64'sd360 <<< ANGLE_FRAC;
    localparam longint OUT_TURN     = 64'sd360 <<< (ANGLE_FRAC - UNIT_SHIFT);
    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
        7334, 3667, 1833, 917, 458, 229, 115, 57, 29
    };

    typedef logic signed [COORD_W-1:0] coord_t;

    class fix_scoreboard;
        typedef struct {
            logic [DIST_W-1:0] distance;
            logic [BEAR_W-1:0] bearing;
        } fix_t;

        fix_t        pending_fixes[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        static function logic [DIST_W-1:0] rounded_root(longint unsigned radicand);
            longint unsigned root;
            longint unsigned rem;
            longint unsigned trial;
            root = 0;
            rem  = 0;
            for (int k = 31; k >= 0; k--) begin
                rem   = (rem << 2) | ((radicand >> (2 * k)) & 64'd3);
                trial = (root << 2) | 64'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root << 1) | 64'd1;
                end
                else begin
                    root = root << 1;
                end
            end
            if (rem > root)
                root++;
            if (root > longint'({DIST_W{1'b1}}))
                root = 64'({DIST_W{1'b1}});
            return root[DIST_W-1:0];
        endfunction

        static function logic [BEAR_W-1:0] vector_angle(longint dx, longint dy);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            longint r;
            x = dx * (64'sd1 <<< (48 - COORD_W));
            y = dy * (64'sd1 <<< (48 - COORD_W));
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP[i];
                end
                else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP[i];
                end
            end
            while (z < 0)
                z = z + FULL_TURN;
            while (z >= FULL_TURN)
                z = z - FULL_TURN;
            r = (z + (64'sd1 <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
            if (r >= OUT_TURN)
                r = r - OUT_TURN;
            return r[BEAR_W-1:0];
        endfunction

        function void note_points(coord_t ox, coord_t oy, coord_t tx, coord_t ty);
            longint dx;
            longint dy;
            fix_t   fix;
            dx = longint'(tx) - longint'(ox);
            dy = longint'(ty) - longint'(oy);
            fix.distance = rounded_root(longint'(dx * dx + dy * dy));
            fix.bearing  = (dx == 0 && dy == 0) ? '0 : vector_angle(dx, dy);
            pending_fixes.push_back(fix);
        endfunction

        function void check_fix(logic [DIST_W-1:0] distance, logic [BEAR_W-1:0] bearing);
            fix_t want;
            if (pending_fixes.size() == 0) begin
                $error("result with no pending item: distance %0d, bearing %0d",
                       distance, bearing);
                errors++;
                return;
            end
            want = pending_fixes.pop_front();
            if (distance !== want.distance) begin
                $error("distance mismatch: expected %0d, actual %0d", want.distance, distance);
                errors++;
            end
            if (bearing !== want.bearing) begin
                $error("bearing mismatch: expected %0d, actual %0d", want.bearing, bearing);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;

    pdb_in_if  pts_ch ();
    pdb_out_if res_ch ();

    fix_scoreboard sb = new();

    point_distance_and_bearing u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pts   (pts_ch),
        .res   (res_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_points(coord_t ox, coord_t oy, coord_t tx, coord_t ty);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0) begin
            pts_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pts_ch.valid    <= 1'b1;
        pts_ch.origin_x <= ox;
        pts_ch.origin_y <= oy;
        pts_ch.target_x <= tx;
        pts_ch.target_y <= ty;
        @(posedge clk);
        while (!pts_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random_points(int n);
        int unsigned kind;
        coord_t      ox;
        coord_t      oy;
        coord_t      tx;
        coord_t      ty;
        int          k;
        coord_t      step;
        kind = $urandom_range(0, 99);
        ox   = coord_t'($urandom);
        oy   = coord_t'($urandom);
        tx   = coord_t'($urandom);
        ty   = coord_t'($urandom);
        k    = $urandom_range(1, 40000);
        step = coord_t'(k / 3);
        steady = (n % 200) >= 150;
        if (kind < 40) begin
        end
        else if (kind < 60) begin
            tx = ox + coord_t'($urandom_range(0, 255)) - coord_t'(128);
            ty = oy + coord_t'($urandom_range(0, 255)) - coord_t'(128);
        end
        else if (kind < 72) begin
            tx = ox + coord_t'($urandom_range(0, 8)) - coord_t'(4);
            ty = oy + coord_t'($urandom_range(0, 8)) - coord_t'(4);
        end
        else if (kind < 85) begin
            ox = coord_t'(-20000 + $urandom_range(0, 40000));
            oy = coord_t'(-20000 + $urandom_range(0, 40000));
            case ($urandom_range(0, 7))
                0: begin tx = ox + step; ty = oy; end
                1: begin tx = ox - step; ty = oy; end
                2: begin tx = ox; ty = oy + step; end
                3: begin tx = ox; ty = oy - step; end
                4: begin tx = ox + step; ty = oy + step; end
                5: begin tx = ox - step; ty = oy + step; end
                6: begin tx = ox - step; ty = oy - step; end
                default: begin tx = ox + step; ty = oy - step; end
            endcase
        end
        else if (kind < 92) begin
            tx = ox;
            ty = oy;
        end
        else begin
            ox = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
            oy = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
            tx = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
        end
        send_points(ox, oy, tx, ty);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pts_ch.valid && pts_ch.ready)
            sb.note_points(pts_ch.origin_x, pts_ch.origin_y, pts_ch.target_x, pts_ch.target_y);
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_fix(res_ch.distance, res_ch.bearing);
    end

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (pts_ch.valid && pts_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("point_distance_and_bearing verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        steady = 1'b0;
        pts_ch.valid    <= 1'b0;
        pts_ch.origin_x <= '0;
        pts_ch.origin_y <= '0;
        pts_ch.target_x <= '0;
        pts_ch.target_y <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coincident points, including at the corners of the range.
        send_points(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_points(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        // Axis directions and diagonals.
        send_points(16'sd0, 16'sd0, 16'sd16, 16'sd0);
        send_points(16'sd0, 16'sd0, 16'sd0, 16'sd16);
        send_points(16'sd0, 16'sd0, -16'sd16, 16'sd0);
        send_points(16'sd0, 16'sd0, 16'sd0, -16'sd16);
        send_points(16'sd100, 16'sd100, 16'sd200, 16'sd200);
        send_points(16'sd100, 16'sd100, 16'sd0, 16'sd200);
        send_points(16'sd100, 16'sd100, 16'sd0, 16'sd0);
        send_points(16'sd100, 16'sd100, 16'sd200, 16'sd0);
        // Unit steps, the smallest vectors.
        send_points(16'sd5, 16'sd5, 16'sd6, 16'sd5);
        send_points(16'sd5, 16'sd5, 16'sd4, 16'sd4);
        send_points(16'sd5, 16'sd5, 16'sd6, 16'sd4);
        // Longest spans, largest distance.
        send_points(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_points(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_points(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_points(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
        send_points(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
        send_points(16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
        // A hair below the +x axis rounds up to a full turn and wraps to zero.
        send_points(-16'sd32768, 16'sd0, 16'sd32767, -16'sd1);
        send_points(16'sd0, 16'sd1, 16'sd30000, 16'sd0);
        // A hair off the -x axis on either side.
        send_points(16'sd32767, 16'sd0, -16'sd32768, -16'sd1);
        send_points(16'sd32767, -16'sd1, -16'sd32768, 16'sd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_random_points(n);
        pts_ch.valid <= 1'b0;

        while (sb.pending_fixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("point_distance_and_bearing verification clean");
        else
            $display("point_distance_and_bearing verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/pdb_pkg.sv
hw/rtl/pdb_in_if.sv
hw/rtl/pdb_out_if.sv
hw/rtl/pdb_core.sv
hw/rtl/point_distance_and_bearing.sv
test/tb_point_distance_and_bearing.sv
